// File: hw/rtl/crc8fd_pkg.sv
// crc8fd_pkg: shared types and constants for the typed crc-8 frame deframer
// covers register codes, config bundle, frame store write request and frame descriptor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crc8fd_pkg;

	localparam int MaxFrameDef = 64;
	localparam int KindCount   = 4;
	localparam int OffW        = 6;
	localparam int CfgIdxW     = 3;
	localparam int CfgDataW    = 32;

	typedef enum logic [CfgIdxW-1:0] {
		RegSync      = 3'd0,
		RegMaxFrame  = 3'd1,
		RegHeader    = 3'd2,
		RegKindIds   = 3'd3,
		RegKindSizes = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  sync_value;
		logic [6:0]  max_frame_size;
		logic [5:0]  header_size;
		logic [31:0] kind_ids;
		logic [31:0] kind_sizes;
	} cfg_t;

	// byte 0 of a frame goes to a per-bank register, the rest to the frame ram
	typedef struct packed {
		logic            mem_en;
		logic            head_en;
		logic            bank;
		logic [OffW-1:0] off;
		logic [7:0]      data;
		logic [7:0]      head_data;
	} wr_req_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [OffW-1:0] len;
	} desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/crc8fd_front.sv
// crc8fd_front: sync hunt, header checks, running crc-8/maxim and kind lookup
// writes frame bytes into the back end's store and pushes a descriptor per good frame
// depends on crc8fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc8fd_front #(
	parameter int MAX_FRAME = crc8fd_pkg::MaxFrameDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  wire [7:0]            rx_byte,
	input  crc8fd_pkg::cfg_t     cfg,
	output crc8fd_pkg::wr_req_t  wr_req,
	output logic                 desc_push,
	output crc8fd_pkg::desc_t    desc
);
	import crc8fd_pkg::*;

	localparam int FrameDepth = (MAX_FRAME < 64) ? MAX_FRAME : 64;
	localparam logic [6:0] FrameLim = 7'(FrameDepth);
	localparam logic [7:0] CrcPoly = 8'h8C;
	localparam int KindChecks = (KindCount < 4) ? KindCount : 4;

	typedef enum logic [1:0] {PhHunt, PhId, PhLen, PhBody} phase_t;

	function automatic logic [7:0] crc_add(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		end
		return r;
	endfunction

	phase_t          phase_q;
	logic [7:0]      held_id_q;
	logic [OffW-1:0] held_len_q;
	logic [OffW-1:0] bt_q;
	logic [7:0]      crc_q;
	logic [7:0]      id_crc_q;
	logic            wr_bank_q;

	logic [7:0]      crc_b, crc0_b, crc_r;
	logic [6:0]      lim;
	logic            len_ok;
	logic [OffW-1:0] bt_inc;
	logic            found;
	logic [1:0]      kind;
	logic            match;

	always_comb begin
		crc_b  = crc_add(crc_q, rx_byte);
		crc0_b = crc_add(8'h00, rx_byte);
		// restart from a bad length: held id becomes byte 0, its crc was kept aside
		crc_r  = crc_add(id_crc_q, rx_byte);
		lim    = (cfg.max_frame_size > FrameLim) ? FrameLim : cfg.max_frame_size;
		len_ok = (rx_byte >= 8'd4) && (rx_byte > {2'b00, cfg.header_size})
			&& (rx_byte < {1'b0, lim});
		bt_inc = bt_q + 6'd1;
		found  = 1'b0;
		kind   = 2'd0;
		for (int k = 0; k < KindChecks; k++) begin
			if (!found && cfg.kind_ids[8*k +: 8] == held_id_q) begin
				found = 1'b1;
				kind  = 2'(k);
			end
		end
		match = found && (cfg.kind_sizes[8*kind +: 8] == {2'b00, held_len_q});
	end

	always_comb begin
		wr_req           = '0;
		wr_req.bank      = wr_bank_q;
		wr_req.off       = bt_q;
		wr_req.data      = rx_byte;
		wr_req.head_data = rx_byte;
		desc_push        = 1'b0;
		desc.kind        = kind;
		desc.len         = held_len_q;
		if (take) begin
			case (phase_q)
				PhHunt: begin
					wr_req.head_en = (rx_byte == cfg.sync_value);
				end
				PhId: begin
					wr_req.mem_en = 1'b1;
				end
				PhLen: begin
					if (len_ok) begin
						wr_req.mem_en = 1'b1;
					end else if (held_id_q == cfg.sync_value) begin
						wr_req.head_en   = 1'b1;
						wr_req.head_data = held_id_q;
						wr_req.mem_en    = 1'b1;
						wr_req.off       = 6'd1;
					end else begin
						wr_req.head_en = (rx_byte == cfg.sync_value);
					end
				end
				PhBody: begin
					wr_req.mem_en = 1'b1;
					desc_push = ({2'b00, bt_inc} >= {2'b00, held_len_q})
						&& (rx_byte == crc_q) && match;
				end
				default: begin
					wr_req = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PhHunt;
			held_id_q  <= '0;
			held_len_q <= '0;
			bt_q       <= '0;
			crc_q      <= '0;
			id_crc_q   <= '0;
			wr_bank_q  <= 1'b0;
		end else if (take) begin
			case (phase_q)
				PhHunt: begin
					if (rx_byte == cfg.sync_value) begin
						bt_q    <= 6'd1;
						crc_q   <= crc0_b;
						phase_q <= PhId;
					end
				end
				PhId: begin
					held_id_q <= rx_byte;
					id_crc_q  <= crc0_b;
					crc_q     <= crc_b;
					bt_q      <= bt_inc;
					phase_q   <= PhLen;
				end
				PhLen: begin
					if (len_ok) begin
						held_len_q <= rx_byte[OffW-1:0];
						crc_q      <= crc_b;
						bt_q       <= bt_inc;
						phase_q    <= PhBody;
					end else if (held_id_q == cfg.sync_value) begin
						held_id_q <= rx_byte;
						id_crc_q  <= crc0_b;
						crc_q     <= crc_r;
						bt_q      <= 6'd2;
						phase_q   <= PhLen;
					end else if (rx_byte == cfg.sync_value) begin
						bt_q    <= 6'd1;
						crc_q   <= crc0_b;
						phase_q <= PhId;
					end else begin
						phase_q <= PhHunt;
					end
				end
				PhBody: begin
					bt_q <= bt_inc;
					if (bt_inc < held_len_q) begin
						crc_q <= crc_b;
					end else begin
						phase_q <= PhHunt;
					end
					if (desc_push) begin
						wr_bank_q <= ~wr_bank_q;
					end
				end
				default: begin
					phase_q <= PhHunt;
				end
			endcase
		end
	end

	a_push_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		desc_push |-> (take && phase_q == PhBody))
		else $error("descriptor pushed outside the body phase");

endmodule

`default_nettype wire

// File: hw/rtl/crc8fd_desc_queue.sv
// crc8fd_desc_queue: two-entry queue of good-frame descriptors between front and back
// one entry per frame store bank, full stalls the front end
// depends on crc8fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc8fd_desc_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  crc8fd_pkg::desc_t  push_desc,
	input  wire                pop,
	output logic               full,
	output logic               avail,
	output crc8fd_pkg::desc_t  head
);
	import crc8fd_pkg::*;

	desc_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("descriptor push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!avail |-> !pop)
		else $error("descriptor pop from an empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/crc8fd_back.sv
// crc8fd_back: two-bank frame store, read sequencer and two-entry result buffer
// replays each queued frame one byte per cycle while the result buffer has room; depends on crc8fd_pkg
`timescale 1ns / 1ps
`default_nettype none

module crc8fd_back #(
	parameter int MAX_FRAME = crc8fd_pkg::MaxFrameDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  crc8fd_pkg::wr_req_t  wr_req,
	input  wire                  desc_avail,
	input  crc8fd_pkg::desc_t    desc_head,
	output logic                 desc_pop,
	input  wire                  pop,
	output logic                 empty,
	output logic [1:0]           frame_kind,
	output logic [5:0]           byte_offset,
	output logic [7:0]           frame_byte,
	output logic                 last_byte
);
	import crc8fd_pkg::*;

	localparam int FrameDepth = (MAX_FRAME < 64) ? MAX_FRAME : 64;
	localparam int AW = $clog2(FrameDepth);

	typedef struct packed {
		logic [1:0]      kind;
		logic [OffW-1:0] off;
		logic [7:0]      data;
		logic            last;
	} res_t;

	logic [7:0]      mem [2**(AW+1)];
	logic [7:0]      head_byte_q [2];

	logic            rd_bank_q;
	logic [OffW-1:0] rd_idx_q;

	logic            valid_s1;
	logic [7:0]      rdata_s1;
	logic [7:0]      head_s1;
	logic            use_head_s1;
	logic [1:0]      kind_s1;
	logic [OffW-1:0] off_s1;
	logic            last_s1;

	res_t            buf_q [2];
	logic            buf_wr_q;
	logic            buf_rd_q;
	logic [1:0]      cnt_q;

	logic            pop_ok;
	logic            issue;
	logic            rd_last;
	logic [1:0]      occ;

	assign empty  = (cnt_q == 2'd0);
	assign pop_ok = pop && !empty;
	assign occ    = cnt_q + {1'b0, valid_s1};
	// keep one slot free for the request in flight unless a result leaves now
	assign issue    = desc_avail && ((occ < 2'd2) || pop_ok);
	assign rd_last  = (rd_idx_q == desc_head.len - 6'd1);
	assign desc_pop = issue && rd_last;

	assign frame_kind  = buf_q[buf_rd_q].kind;
	assign byte_offset = buf_q[buf_rd_q].off;
	assign frame_byte  = buf_q[buf_rd_q].data;
	assign last_byte   = buf_q[buf_rd_q].last;

	always_ff @(posedge clk) begin
		if (wr_req.mem_en) begin
			mem[{wr_req.bank, wr_req.off[AW-1:0]}] <= wr_req.data;
		end
		if (wr_req.head_en) begin
			head_byte_q[wr_req.bank] <= wr_req.head_data;
		end
		if (issue) begin
			rdata_s1    <= mem[{rd_bank_q, rd_idx_q[AW-1:0]}];
			head_s1     <= head_byte_q[rd_bank_q];
			use_head_s1 <= (rd_idx_q == 6'd0);
			kind_s1     <= desc_head.kind;
			off_s1      <= rd_idx_q;
			last_s1     <= rd_last;
		end
		if (valid_s1) begin
			buf_q[buf_wr_q].kind <= kind_s1;
			buf_q[buf_wr_q].off  <= off_s1;
			buf_q[buf_wr_q].data <= use_head_s1 ? head_s1 : rdata_s1;
			buf_q[buf_wr_q].last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_bank_q <= 1'b0;
			rd_idx_q  <= '0;
			valid_s1  <= 1'b0;
			buf_wr_q  <= 1'b0;
			buf_rd_q  <= 1'b0;
			cnt_q     <= 2'd0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				if (rd_last) begin
					rd_idx_q  <= '0;
					rd_bank_q <= ~rd_bank_q;
				end else begin
					rd_idx_q <= rd_idx_q + 6'd1;
				end
			end
			if (valid_s1) begin
				buf_wr_q <= ~buf_wr_q;
			end
			if (pop_ok) begin
				buf_rd_q <= ~buf_rd_q;
			end
			cnt_q <= cnt_q + {1'b0, valid_s1} - {1'b0, pop_ok};
		end
	end

	a_buffer_room: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= 2'd2)
		else $error("result buffer and read in flight exceed two entries");

	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |=> (rd_idx_q == 6'd0 && rd_bank_q != $past(rd_bank_q)))
		else $error("read sequencer did not move to the next bank");

endmodule

`default_nettype wire

// File: hw/rtl/typed_crc8_frame_deframer_top.sv
// typed_crc8_frame_deframer_top: configuration registers and wiring of front, queue and back
// depends on crc8fd_pkg, crc8fd_front, crc8fd_desc_queue, crc8fd_back
//
//  channel   ports                                             request taken when
//  input     push, full, rx_byte                               push && !full
//  result    empty, pop, frame_kind, byte_offset,              pop && !empty
//            frame_byte, last_byte
//  config    cfg_we, cfg_index, cfg_data                       cfg_we
//
// the front end takes one byte every cycle while full is low; crc and header checks finish in that cycle
// a good frame replays from the frame store one result per cycle while the result buffer
// has room, each via the ram read register; the single ram read port sets that pace
// full rises while two good frames wait in the two store banks, until one drains
// reset clears all control state at once; the frame store needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module typed_crc8_frame_deframer_top #(
	parameter int MAX_FRAME = crc8fd_pkg::MaxFrameDef
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               push,
	output logic                              full,
	input  wire [7:0]                         rx_byte,
	output logic                              empty,
	input  wire                               pop,
	output logic [1:0]                        frame_kind,
	output logic [5:0]                        byte_offset,
	output logic [7:0]                        frame_byte,
	output logic                              last_byte,
	input  wire                               cfg_we,
	input  wire [crc8fd_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire [crc8fd_pkg::CfgDataW-1:0]    cfg_data
);
	import crc8fd_pkg::*;

	cfg_t    cfg_q;
	wr_req_t wr_req;
	desc_t   push_desc;
	desc_t   desc_head;
	logic    desc_push;
	logic    desc_pop;
	logic    desc_avail;
	logic    take;

	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value     <= 8'd0;
			cfg_q.max_frame_size <= 7'd64;
			cfg_q.header_size    <= 6'd3;
			cfg_q.kind_ids       <= 32'd0;
			cfg_q.kind_sizes     <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				RegSync:      cfg_q.sync_value     <= cfg_data[7:0];
				RegMaxFrame:  cfg_q.max_frame_size <= cfg_data[6:0];
				RegHeader:    cfg_q.header_size    <= cfg_data[5:0];
				RegKindIds:   cfg_q.kind_ids       <= cfg_data;
				RegKindSizes: cfg_q.kind_sizes     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crc8fd_front #(
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.wr_req    (wr_req),
		.desc_push (desc_push),
		.desc      (push_desc)
	);

	crc8fd_desc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (desc_push),
		.push_desc (push_desc),
		.pop       (desc_pop),
		.full      (full),
		.avail     (desc_avail),
		.head      (desc_head)
	);

	crc8fd_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_req      (wr_req),
		.desc_avail  (desc_avail),
		.desc_head   (desc_head),
		.desc_pop    (desc_pop),
		.pop         (pop),
		.empty       (empty),
		.frame_kind  (frame_kind),
		.byte_offset (byte_offset),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

endmodule

`default_nettype wire
